### rtl/smm_pkg.sv
// Shared types and constants for the saturating matrix multiply block.
// Used by smm_mac and saturating_matrix_multiply; depends on nothing.
package smm_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_LEN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAT_EN    = 2'd2;

    // reset values of the configuration registers
    localparam logic [5:0] INNER_LEN_RST = 6'd32;
    localparam logic [4:0] OUT_COUNT_RST = 5'd16;

    // fixed field widths
    localparam int ROW_FIELD_W   = 4;
    localparam int COL_FIELD_W   = 5;
    localparam int INDEX_FIELD_W = 4;

    // request kinds
    localparam logic FUNC_WEIGHT     = 1'b0;
    localparam logic FUNC_ACTIVATION = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_WAIT  = 3'b100
    } smm_state_t;

    // tag that travels with each product down the multiply-accumulate pipe
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } smm_tag_t;

endpackage

### rtl/smm_mac.sv
// Shared multiply-accumulate unit: one product per cycle, running sum per row,
// final clamp or wrap to the element width. Depends on smm_pkg.
module smm_mac
    import smm_pkg::*;
#(
    parameter int ELEM_BITS = 8,
    parameter int MAX_INNER = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [ELEM_BITS-1:0] act,
    input  logic signed [ELEM_BITS-1:0] wgt,
    input  smm_tag_t                    tag,
    input  logic                        sat_en,
    output logic                        done,
    output logic signed [ELEM_BITS-1:0] result
);

    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_INNER) + 1;
    // running sum is held to +-2^61 only when saturation is enabled and it could ever get that large
    localparam bit NEED_CLAMP = ACC_W > 62;
    localparam logic signed [ACC_W-1:0] ACC_LIM =
        NEED_CLAMP ? ({{(ACC_W-1){1'b0}}, 1'b1} << 61) : '0;
    localparam logic signed [ACC_W-1:0] ELEM_MAX =
        $signed({{(ACC_W-ELEM_BITS+1){1'b0}}, {(ELEM_BITS-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] ELEM_MIN =
        $signed({{(ACC_W-ELEM_BITS+1){1'b1}}, {(ELEM_BITS-1){1'b0}}});

    logic signed [PROD_W-1:0] prod_reg;
    smm_tag_t                 tag_c_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;

    always_comb
    begin
        acc_next = (tag_c_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
        if (sat_en && NEED_CLAMP)
        begin
            if (acc_next > ACC_LIM)
                acc_next = ACC_LIM;
            else if (acc_next < -ACC_LIM)
                acc_next = -ACC_LIM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_c_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tag_c_reg <= tag;
            done_reg  <= tag_c_reg.valid && tag_c_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= act * wgt;
        if (tag_c_reg.valid)
            acc_reg <= acc_next;
    end

    always_comb
    begin
        if (sat_en && acc_reg > ELEM_MAX)
            result = ELEM_MAX[ELEM_BITS-1:0];
        else if (sat_en && acc_reg < ELEM_MIN)
            result = ELEM_MIN[ELEM_BITS-1:0];
        else
            result = acc_reg[ELEM_BITS-1:0];
    end

    assign done = done_reg;

endmodule

### rtl/saturating_matrix_multiply.sv
// Top level of the saturating matrix multiply: weight store, activation buffer,
// row sequencer and output register. Depends on smm_pkg and smm_mac.
//
//  channel   direction  handshake              payload
//  in        request    in_valid / in_stall    func, weight_row, weight_col, value
//  out       result     out_valid / out_stall  out_index, out_value, last
//  cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A weight request, or an activation not closing a row, only writes its store.
// An activation that closes a row runs out_count dot products in turn on the single
// multiplier, each issuing one weight read per cycle through the read, multiply and
// accumulate stages, then hands its result to the output register. Reset clears the
// sequencer and row position, presets config registers; the stores start unknown.
// in_stall is high for the whole run; out_stall holds the run at the output register.
module saturating_matrix_multiply
    import smm_pkg::*;
#(
    parameter int MAX_OUTS  = 16,
    parameter int MAX_INNER = 32,
    parameter int ELEM_BITS = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [ROW_FIELD_W-1:0]      weight_row,
    input  logic [COL_FIELD_W-1:0]      weight_col,
    input  logic signed [ELEM_BITS-1:0] value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [INDEX_FIELD_W-1:0]    out_index,
    output logic signed [ELEM_BITS-1:0] out_value,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int COL_W   = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int ROW_W   = (MAX_OUTS > 1) ? $clog2(MAX_OUTS) : 1;
    localparam int WDEPTH  = MAX_OUTS * MAX_INNER;
    localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    // configuration registers
    logic [5:0] inner_len_reg;
    logic [4:0] out_count_reg;
    logic       sat_en_reg;

    // stores
    logic signed [ELEM_BITS-1:0] weight_mem [WDEPTH];
    logic signed [ELEM_BITS-1:0] act_mem    [MAX_INNER];

    smm_state_t       state_reg, state_next;
    logic [COL_W-1:0] pos_reg, pos_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] k_reg, k_next;
    logic [COL_W-1:0] len_m1_reg, len_m1_next;
    logic [ROW_W-1:0] cnt_m1_reg, cnt_m1_next;
    logic             have_res_reg;
    logic             out_valid_reg;
    logic [INDEX_FIELD_W-1:0]    out_index_reg;
    logic signed [ELEM_BITS-1:0] out_value_reg;
    logic                        last_reg;

    logic [COL_W-1:0] cfg_len_m1;
    logic [ROW_W-1:0] cfg_cnt_m1;
    logic             in_accept;
    logic             out_free;
    logic             consume;
    logic             wr_ok;
    logic [WADDR_W-1:0] wr_addr;
    logic [WADDR_W-1:0] rd_addr;
    smm_tag_t         issue_tag;
    smm_tag_t         tag_b_reg;
    logic signed [ELEM_BITS-1:0] act_rd_reg;
    logic signed [ELEM_BITS-1:0] wgt_rd_reg;
    logic             mac_done;
    logic signed [ELEM_BITS-1:0] mac_result;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // register values held to their legal ranges
    always_comb
    begin
        int il;
        int oc;
        il = int'(inner_len_reg);
        oc = int'(out_count_reg);
        if (il < 1)
            il = 1;
        else if (il > MAX_INNER)
            il = MAX_INNER;
        if (oc < 1)
            oc = 1;
        else if (oc > MAX_OUTS)
            oc = MAX_OUTS;
        cfg_len_m1 = COL_W'(il - 1);
        cfg_cnt_m1 = ROW_W'(oc - 1);
    end

    assign wr_ok   = (int'(weight_row) < MAX_OUTS) && (int'(weight_col) < MAX_INNER);
    assign wr_addr = WADDR_W'(int'(weight_row) * MAX_INNER + int'(weight_col));
    assign rd_addr = WADDR_W'(int'(k_reg) * MAX_INNER + int'(col_reg));

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        col_next    = col_reg;
        k_next      = k_reg;
        len_m1_next = len_m1_reg;
        cnt_m1_next = cnt_m1_reg;
        issue_tag   = '0;
        consume     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && func == FUNC_ACTIVATION)
                begin
                    if (pos_reg >= cfg_len_m1)
                    begin
                        pos_next    = '0;
                        col_next    = '0;
                        k_next      = '0;
                        len_m1_next = cfg_len_m1;
                        cnt_m1_next = cfg_cnt_m1;
                        state_next  = S_ISSUE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            S_ISSUE:
            begin
                issue_tag.valid = 1'b1;
                issue_tag.first = (col_reg == '0);
                issue_tag.last  = (col_reg == len_m1_reg);
                if (col_reg == len_m1_reg)
                    state_next = S_WAIT;
                else
                    col_next = col_reg + 1'b1;
            end
            S_WAIT:
            begin
                if (have_res_reg && out_free)
                begin
                    consume = 1'b1;
                    if (k_reg == cnt_m1_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        col_next   = '0;
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            len_m1_reg    <= '0;
            cnt_m1_reg    <= '0;
            have_res_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tag_b_reg     <= '0;
            inner_len_reg <= INNER_LEN_RST;
            out_count_reg <= OUT_COUNT_RST;
            sat_en_reg    <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            col_reg    <= col_next;
            k_reg      <= k_next;
            len_m1_reg <= len_m1_next;
            cnt_m1_reg <= cnt_m1_next;
            tag_b_reg  <= issue_tag;
            if (mac_done)
                have_res_reg <= 1'b1;
            else if (consume)
                have_res_reg <= 1'b0;
            if (consume)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_INNER_LEN: inner_len_reg <= cfg_data;
                    REG_OUT_COUNT: out_count_reg <= cfg_data[4:0];
                    REG_SAT_EN:    sat_en_reg    <= cfg_data[0];
                    default:       ;
                endcase
            end
        end
    end

    // stores and read ports
    always_ff @(posedge clk)
    begin
        if (in_accept && func == FUNC_WEIGHT && wr_ok)
            weight_mem[wr_addr] <= value;
        if (in_accept && func == FUNC_ACTIVATION)
            act_mem[pos_reg] <= value;
        wgt_rd_reg <= weight_mem[rd_addr];
        act_rd_reg <= act_mem[col_reg];
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            out_index_reg <= INDEX_FIELD_W'(k_reg);
            out_value_reg <= mac_result;
            last_reg      <= (k_reg == cnt_m1_reg);
        end
    end

    smm_mac #(
        .ELEM_BITS (ELEM_BITS),
        .MAX_INNER (MAX_INNER)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .act    (act_rd_reg),
        .wgt    (wgt_rd_reg),
        .tag    (tag_b_reg),
        .sat_en (sat_en_reg),
        .done   (mac_done),
        .result (mac_result)
    );

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

endmodule
